// ----- rtl/sfcr_pkg.sv -----
package sfcr_pkg;

   // Frame layout: start, start, version, type, sequence, parameter,
   // four value bytes (little-endian), CRC.
   localparam int FRAME_LEN = 11;
   localparam int POS_WIDTH = $clog2(FRAME_LEN);

   localparam logic [POS_WIDTH-1:0] POS_HUNT     = POS_WIDTH'(0);
   localparam logic [POS_WIDTH-1:0] POS_SECOND   = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] POS_VERSION  = POS_WIDTH'(2);
   localparam logic [POS_WIDTH-1:0] POS_CRC      = POS_WIDTH'(FRAME_LEN - 1);

   localparam int IDX_TYPE     = 3;
   localparam int IDX_SEQUENCE = 4;
   localparam int IDX_PARAM    = 5;
   localparam int IDX_VALUE    = 6;

   localparam logic [7:0] CRC_POLY = 8'h07;

   localparam logic [1:0] VERDICT_GOOD    = 2'd0;
   localparam logic [1:0] VERDICT_VERSION = 2'd1;
   localparam logic [1:0] VERDICT_CRC     = 2'd2;

   localparam logic REQ_TYPE_BYTE = 1'b0;
   localparam logic REQ_TYPE_TICK = 1'b1;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOF_FIRST    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOF_SECOND   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERSION      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINK_TIMEOUT = 2'd3;

   localparam logic [7:0]  RESET_SOF_FIRST    = 8'hA5;
   localparam logic [7:0]  RESET_SOF_SECOND   = 8'h5A;
   localparam logic [7:0]  RESET_VERSION      = 8'h01;
   localparam logic [15:0] RESET_LINK_TIMEOUT = 16'd1000;

   localparam logic [15:0] IDLE_AGE_MAX = 16'hFFFF;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         verdict;
      logic [7:0]         frame_type;
      logic [7:0]         sequence_number;
      logic [7:0]         param_id;
      logic signed [31:0] param_value;
      logic               link_up;
      logic [31:0]        good_frames;
      logic [31:0]        crc_errors;
      logic [31:0]        version_errors;
   } rsp_payload_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] c;
      c = acc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/sof_framed_crc8_receiver_core.sv -----
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    req_payload_type (byte or tick)
// rsp       out        rsp_valid / rsp_stall    rsp_payload_type (frame verdict)
// csr       in         csr_write_enable         csr_index, csr_wdata
//
// One beat is taken every cycle while req_stall is low. A beat passes an input
// register and, when it closes a frame, then lands in the result register.
// The rate is set by the single processing step between those two registers.
// Reset is synchronous and active high; it clears the hunt position, CRC,
// link state and counters and restores the register defaults.
// req_stall rises only while the input register holds a beat and a finished
// result is still waiting on a stalled rsp channel.
module sof_framed_crc8_receiver_core
   import sfcr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,

   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Configuration registers.
   logic [7:0]  sof_first_ff;
   logic [7:0]  sof_second_ff;
   logic [7:0]  version_ff;
   logic [15:0] timeout_ff;

   // Input register.
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_payload_ff;

   // Receiver state.
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]           crc_ff, crc_in;
   logic                 link_ff, link_in;
   logic                 seen_ff, seen_in;
   logic [15:0]          idle_ff, idle_in;
   logic [31:0]          good_ff, good_in;
   logic [31:0]          crc_err_ff, crc_err_in;
   logic [31:0]          ver_err_ff, ver_err_in;

   // Frame bytes, written at the store position, read at fixed places.
   logic [7:0] frame_ff [FRAME_LEN];

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                 advance;
   logic                 frame_done;
   logic                 store_en;
   logic [POS_WIDTH-1:0] store_pos;
   logic [7:0]           b;

   // The processing step runs whenever the input register holds a beat and the result
   // register can take a result, whether or not this beat produces one.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign b         = s1_payload_ff.rx_byte;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = (advance && frame_done) || (rsp_valid_ff && rsp_stall);

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      link_in    = link_ff;
      seen_in    = seen_ff;
      idle_in    = idle_ff;
      good_in    = good_ff;
      crc_err_in = crc_err_ff;
      ver_err_in = ver_err_ff;
      store_en   = 1'b0;
      store_pos  = pos_ff;
      frame_done = 1'b0;

      rsp_payload_in.verdict         = VERDICT_GOOD;
      rsp_payload_in.frame_type      = frame_ff[IDX_TYPE];
      rsp_payload_in.sequence_number = frame_ff[IDX_SEQUENCE];
      rsp_payload_in.param_id        = frame_ff[IDX_PARAM];
      rsp_payload_in.param_value     = {frame_ff[IDX_VALUE+3], frame_ff[IDX_VALUE+2],
                                        frame_ff[IDX_VALUE+1], frame_ff[IDX_VALUE]};
      rsp_payload_in.link_up         = link_ff;
      rsp_payload_in.good_frames     = good_ff;
      rsp_payload_in.crc_errors      = crc_err_ff;
      rsp_payload_in.version_errors  = ver_err_ff;

      if (advance) begin
         if (s1_payload_ff.req_type == REQ_TYPE_TICK) begin
            // The link drops on the tick that takes the idle time past the timeout.
            if (seen_ff && (idle_ff >= timeout_ff)) begin
               link_in = 1'b0;
            end else if (idle_ff != IDLE_AGE_MAX) begin
               idle_in = idle_ff + 16'd1;
            end
         end else if (pos_ff == POS_HUNT) begin
            if (b == sof_first_ff) begin
               store_en = 1'b1;
               pos_in   = POS_SECOND;
            end
         end else if (pos_ff == POS_SECOND) begin
            if (b == sof_second_ff) begin
               store_en = 1'b1;
               pos_in   = POS_VERSION;
            end else if (b == sof_first_ff) begin
               // A repeated first start byte keeps the hunt at the second byte.
               store_en  = 1'b1;
               store_pos = POS_HUNT;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_CRC) begin
            pos_in     = POS_HUNT;
            frame_done = 1'b1;
            if (frame_ff[POS_VERSION] != version_ff) begin
               ver_err_in                     = ver_err_ff + 32'd1;
               rsp_payload_in.verdict         = VERDICT_VERSION;
            end else if (crc_ff != b) begin
               crc_err_in                     = crc_err_ff + 32'd1;
               rsp_payload_in.verdict         = VERDICT_CRC;
            end else begin
               good_in = good_ff + 32'd1;
               link_in = 1'b1;
               seen_in = 1'b1;
               idle_in = 16'd0;
               rsp_payload_in.verdict         = VERDICT_GOOD;
            end
            rsp_payload_in.link_up        = link_in;
            rsp_payload_in.good_frames    = good_in;
            rsp_payload_in.crc_errors     = crc_err_in;
            rsp_payload_in.version_errors = ver_err_in;
         end else begin
            // Version up to the last value byte: store and fold into the CRC.
            store_en = 1'b1;
            pos_in   = pos_ff + POS_WIDTH'(1);
            if (pos_ff == POS_VERSION) begin
               crc_in = crc8_byte(8'h00, b);
            end else begin
               crc_in = crc8_byte(crc_ff, b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sof_first_ff  <= RESET_SOF_FIRST;
         sof_second_ff <= RESET_SOF_SECOND;
         version_ff    <= RESET_VERSION;
         timeout_ff    <= RESET_LINK_TIMEOUT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SOF_FIRST:    sof_first_ff  <= csr_wdata[7:0];
            CSR_SOF_SECOND:   sof_second_ff <= csr_wdata[7:0];
            CSR_VERSION:      version_ff    <= csr_wdata[7:0];
            CSR_LINK_TIMEOUT: timeout_ff    <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= POS_HUNT;
         crc_ff       <= 8'h00;
         link_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         idle_ff      <= 16'd0;
         good_ff      <= 32'd0;
         crc_err_ff   <= 32'd0;
         ver_err_ff   <= 32'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         link_ff      <= link_in;
         seen_ff      <= seen_in;
         idle_ff      <= idle_in;
         good_ff      <= good_in;
         crc_err_ff   <= crc_err_in;
         ver_err_ff   <= ver_err_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_payload_ff <= req_payload;
      end
      if (store_en) begin
         frame_ff[store_pos] <= b;
      end
      if (advance && frame_done) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
